/* rtl/ndpm_pkg.sv */
// ============================================================================
// ndpm_pkg: shared types and constants for the NTT pair multiplier
// Holds the modulus, the Montgomery constants, the twiddle table and the
// two halves of a Montgomery reduction used by the pipeline stages.
// ============================================================================
package ndpm_pkg;

   // Number of register stages from the request side to the result register.
   localparam int unsigned STAGES = 7;

   // Field widths.
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned IDX_W   = 7;
   localparam int unsigned RES_W   = 14;
   localparam int unsigned ZETA_W  = 13;
   localparam int unsigned PROD_W  = 32;

   // Modulus and the low 16 bits of q^-1 mod 2^16 (QINV = -3327).
   localparam logic signed [12:0] MOD_Q     = 13'sd3329;
   localparam logic [15:0]        QINV_LOW  = 16'hF301;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ZETA_W-1:0] zeta_type;
   typedef logic signed [RES_W-1:0]  res_type;

   // Twiddle magnitudes; the table alternates +z and -z, so the low index bit
   // gives the sign and the upper six bits pick the magnitude.
   localparam logic [11:0] ZETA_MAG [64] = '{
      12'd2226, 12'd430,  12'd555,  12'd843,  12'd2078, 12'd871,  12'd1550, 12'd105,
      12'd422,  12'd587,  12'd177,  12'd3094, 12'd3038, 12'd2869, 12'd1574, 12'd1653,
      12'd3083, 12'd778,  12'd1159, 12'd3182, 12'd2552, 12'd1483, 12'd2727, 12'd1119,
      12'd1739, 12'd644,  12'd2457, 12'd349,  12'd418,  12'd329,  12'd3173, 12'd3254,
      12'd817,  12'd1097, 12'd603,  12'd610,  12'd1322, 12'd2044, 12'd1864, 12'd384,
      12'd2114, 12'd3193, 12'd1218, 12'd1994, 12'd2455, 12'd220,  12'd2142, 12'd1670,
      12'd2144, 12'd1799, 12'd2051, 12'd794,  12'd1819, 12'd2475, 12'd2459, 12'd478,
      12'd3221, 12'd3021, 12'd996,  12'd991,  12'd958,  12'd1869, 12'd1522, 12'd1628
   };

   // Signed twiddle for a pair position.
   function automatic zeta_type zeta_of(input logic [IDX_W-1:0] idx);
      zeta_type mag;
      mag = zeta_type'({1'b0, ZETA_MAG[idx[IDX_W-1:1]]});
      return idx[0] ? -mag : mag;
   endfunction

   // First half of a Montgomery reduction: u = low16(p * QINV), read as signed.
   function automatic coef_type mont_u(input logic [COEF_W-1:0] p_low);
      logic [2*COEF_W-1:0] full;
      full = p_low * QINV_LOW;
      return coef_type'(full[COEF_W-1:0]);
   endfunction

   // Second half: (p - u*q) / 2^16, exact, so the upper half is the quotient.
   function automatic coef_type mont_t(input prod_type p, input coef_type u);
      logic signed [COEF_W+ZETA_W-1:0] uq;
      prod_type                        t;
      uq = u * MOD_Q;
      t  = p - PROD_W'(uq);
      return coef_type'(t[PROD_W-1:COEF_W]);
   endfunction

endpackage

/* rtl/ntt_domain_pair_multiplier.sv */
// ============================================================================
// ntt_domain_pair_multiplier: pipelined base multiplication in the NTT domain
// Multiplies two degree-one polynomials modulo X^2 - zeta, q = 3329, with
// every product taken through a Montgomery reduction (factor 2^-16).
// ============================================================================
// The block takes one coefficient pair per cycle while the result side does
// not stall, and returns one result beat per request beat, in order. The depth
// of the pipeline is set by the two chained Montgomery products on the even
// path: each one is a coefficient multiply, a multiply by QINV and a
// multiply-subtract by q, one register stage each, followed by the final add.
// Stalls on the result side ripple back through a per-stage valid chain, so
// empty stages keep filling while a result waits.
module ntt_domain_pair_multiplier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: pair_index[6:0], a_even[22:7], a_odd[38:23], b_even[54:39],
   //        b_odd[70:55], zero pad [71]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: r_even[13:0], r_odd[27:14], zero pad [31:28]
   output logic [31:0] rsp_tdata
);

   localparam int unsigned NS = ndpm_pkg::STAGES;

   // Request fields.
   logic [ndpm_pkg::IDX_W-1:0] pair_index;
   ndpm_pkg::coef_type         a_even, a_odd, b_even, b_odd;

   assign pair_index = req_tdata[6:0];
   assign a_even     = ndpm_pkg::coef_type'(req_tdata[22:7]);
   assign a_odd      = ndpm_pkg::coef_type'(req_tdata[38:23]);
   assign b_even     = ndpm_pkg::coef_type'(req_tdata[54:39]);
   assign b_odd      = ndpm_pkg::coef_type'(req_tdata[70:55]);

   // Valid chain and per-stage load enables.
   logic [NS-1:0] vld_ff, vld_in, load;

   always_comb begin
      load[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         load[i] = !vld_ff[i] || load[i+1];
      end
      vld_in[0] = load[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = load[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = load[0];

   // Stage 1: the four coefficient products and the twiddle lookup.
   ndpm_pkg::prod_type p_ee_ff, p_oo_ff, p_eo_ff, p_oe_ff;
   ndpm_pkg::prod_type p_ee_in, p_oo_in, p_eo_in, p_oe_in;
   ndpm_pkg::zeta_type z1_ff, z1_in;

   always_comb begin
      p_ee_in = a_even * b_even;
      p_oo_in = a_odd  * b_odd;
      p_eo_in = a_even * b_odd;
      p_oe_in = a_odd  * b_even;
      z1_in   = ndpm_pkg::zeta_of(pair_index);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         p_ee_ff <= p_ee_in;
         p_oo_ff <= p_oo_in;
         p_eo_ff <= p_eo_in;
         p_oe_ff <= p_oe_in;
         z1_ff   <= z1_in;
      end
   end

   // Stage 2: Montgomery quotients of the four products.
   ndpm_pkg::coef_type u_ee_ff, u_oo_ff, u_eo_ff, u_oe_ff;
   ndpm_pkg::coef_type u_ee_in, u_oo_in, u_eo_in, u_oe_in;
   ndpm_pkg::prod_type p2_ee_ff, p2_oo_ff, p2_eo_ff, p2_oe_ff;
   ndpm_pkg::zeta_type z2_ff;

   always_comb begin
      u_ee_in = ndpm_pkg::mont_u(p_ee_ff[15:0]);
      u_oo_in = ndpm_pkg::mont_u(p_oo_ff[15:0]);
      u_eo_in = ndpm_pkg::mont_u(p_eo_ff[15:0]);
      u_oe_in = ndpm_pkg::mont_u(p_oe_ff[15:0]);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         u_ee_ff  <= u_ee_in;
         u_oo_ff  <= u_oo_in;
         u_eo_ff  <= u_eo_in;
         u_oe_ff  <= u_oe_in;
         p2_ee_ff <= p_ee_ff;
         p2_oo_ff <= p_oo_ff;
         p2_eo_ff <= p_eo_ff;
         p2_oe_ff <= p_oe_ff;
         z2_ff    <= z1_ff;
      end
   end

   // Stage 3: finish the four reductions.
   ndpm_pkg::coef_type m_ee_ff, m_oo_ff, m_eo_ff, m_oe_ff;
   ndpm_pkg::coef_type m_ee_in, m_oo_in, m_eo_in, m_oe_in;
   ndpm_pkg::zeta_type z3_ff;

   always_comb begin
      m_ee_in = ndpm_pkg::mont_t(p2_ee_ff, u_ee_ff);
      m_oo_in = ndpm_pkg::mont_t(p2_oo_ff, u_oo_ff);
      m_eo_in = ndpm_pkg::mont_t(p2_eo_ff, u_eo_ff);
      m_oe_in = ndpm_pkg::mont_t(p2_oe_ff, u_oe_ff);
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         m_ee_ff <= m_ee_in;
         m_oo_ff <= m_oo_in;
         m_eo_ff <= m_eo_in;
         m_oe_ff <= m_oe_in;
         z3_ff   <= z2_ff;
      end
   end

   // Stage 4: odd result is complete; the odd-odd term is scaled by zeta.
   logic signed [ndpm_pkg::COEF_W:0]                  ro_sum;
   logic signed [ndpm_pkg::COEF_W+ndpm_pkg::ZETA_W-1:0] pz_ff, pz_in;
   ndpm_pkg::res_type  ro4_ff, ro4_in;
   ndpm_pkg::coef_type me4_ff;

   always_comb begin
      ro_sum = (ndpm_pkg::COEF_W+1)'(m_eo_ff) + (ndpm_pkg::COEF_W+1)'(m_oe_ff);
      ro4_in = ro_sum[ndpm_pkg::RES_W-1:0];
      pz_in  = m_oo_ff * z3_ff;
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         pz_ff  <= pz_in;
         ro4_ff <= ro4_in;
         me4_ff <= m_ee_ff;
      end
   end

   // Stage 5: Montgomery quotient of the zeta product.
   ndpm_pkg::coef_type uz_ff, uz_in;
   ndpm_pkg::prod_type pz5_ff;
   ndpm_pkg::res_type  ro5_ff;
   ndpm_pkg::coef_type me5_ff;

   assign uz_in = ndpm_pkg::mont_u(pz_ff[15:0]);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         uz_ff  <= uz_in;
         pz5_ff <= ndpm_pkg::PROD_W'(pz_ff);
         ro5_ff <= ro4_ff;
         me5_ff <= me4_ff;
      end
   end

   // Stage 6: finish the zeta reduction.
   ndpm_pkg::coef_type mz_ff, mz_in;
   ndpm_pkg::res_type  ro6_ff;
   ndpm_pkg::coef_type me6_ff;

   assign mz_in = ndpm_pkg::mont_t(pz5_ff, uz_ff);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         mz_ff  <= mz_in;
         ro6_ff <= ro5_ff;
         me6_ff <= me5_ff;
      end
   end

   // Stage 7: even sum, wrapped to the result width, into the output register.
   logic signed [ndpm_pkg::COEF_W:0] re_sum;
   ndpm_pkg::res_type re_ff, re_in, ro_ff;

   always_comb begin
      re_sum = (ndpm_pkg::COEF_W+1)'(me6_ff) + (ndpm_pkg::COEF_W+1)'(mz_ff);
      re_in  = re_sum[ndpm_pkg::RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         re_ff <= re_in;
         ro_ff <= ro6_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {4'b0, ro_ff, re_ff};

   // Taking a result always frees room for a new request in the same cycle.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("result taken but request side not ready");

   // A middle stage that cannot move keeps its beat.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && !load[3] |=> vld_ff[3])
      else $error("stalled beat lost in middle stage");

   // A beat entering the output register shows up as a result.
   a_out_follow: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-2] && load[NS-1] |=> rsp_tvalid)
      else $error("beat dropped before the result register");

endmodule
